>>> rtl/core/jdc_pkg.sv
// Constants, codes and tables shared by the Julian day converter.
`default_nettype none

package jdc_pkg;

  localparam int JD_W    = 23;
  localparam int YEAR_W  = 15;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  typedef enum logic {
    OP_DATE_TO_JD = 1'b0,
    OP_JD_TO_DATE = 1'b1
  } op_t;

  // First Gregorian date, 1582-10-15, and its day number
  localparam logic signed [15:0] GREG_YEAR  = 16'sd1582;
  localparam logic [3:0]         GREG_MONTH = 4'd10;
  localparam logic [4:0]         GREG_DAY   = 5'd15;
  localparam logic [22:0]        GREG_SWITCH_JD = 23'd2299161;

  localparam logic signed [25:0] JD_DATE_OFFSET = 26'sd1720995;

  // year / 100 for years below 43699
  localparam logic [12:0] Y100_RECIP = 13'd5243;
  localparam int          Y100_SHIFT = 19;

  // alpha = (4*z - 7468865) / 146097, exact reciprocal for 25-bit dividends
  localparam logic [22:0] ALPHA_OFS4  = 23'd7468865;
  localparam longint      ALPHA_DIV   = 146097;
  localparam int          ALPHA_SHIFT = 43;
  localparam logic [25:0] ALPHA_RECIP = 26'(((64'd1 << ALPHA_SHIFT) / ALPHA_DIV) + 1);

  localparam logic [23:0] B_OFFSET = 24'd1524;

  // c = (4*b - 489) / 1461, exact reciprocal for 26-bit dividends
  localparam logic [25:0] C_OFS4  = 26'd489;
  localparam longint      C_DIV   = 1461;
  localparam int          C_SHIFT = 37;
  localparam logic [26:0] C_RECIP = 27'(((64'd1 << C_SHIFT) / C_DIV) + 1);

  // e = 10000*x / 306001 for x below 512
  localparam longint      E_NUM   = 10000;
  localparam longint      E_DIV   = 306001;
  localparam int          E_SHIFT = 30;
  localparam logic [25:0] E_RECIP = 26'((((64'd1 << E_SHIFT) * E_NUM) / E_DIV) + 1);

  localparam logic signed [15:0] YEAR_BASE_LATE  = 16'sd4716;
  localparam logic signed [15:0] YEAR_BASE_EARLY = 16'sd4715;

  // floor(30.6001 * k)
  function automatic logic [8:0] month_days(input logic [4:0] k);
    logic [8:0] r;
    case (k)
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/julian_day_converter.sv
// Calendar date to Julian day number converter and its inverse, seven-stage pipeline.
//
// Takes one request per cycle while the output side is not stalled and returns one
// result per request, in order, through the register pipeline. All stages advance
// together and hold while a result waits at the output, so a stall loses and repeats
// nothing. Direction is selected by tuser: 0 converts a date (Julian calendar before
// 1582-10-15, Gregorian from then on, no year zero) to a day number; 1 converts a day
// number to a date, with the Gregorian correction from day 2299161 on. Fields not
// produced by the selected direction read as zero. Out-of-range inputs are not
// checked; results wrap to their field widths.
`default_nettype none

module julian_day_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // year_in[14:0], month_in[18:15], day_in[23:19], day_number_in[46:24], zero pad
  input  wire logic [47:0] s_axis_tdata,
  // operation[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // day_number_out[22:0], year_out[37:23], month_out[41:38], day_out[46:42], zero pad
  output logic [47:0]      m_axis_tdata
);

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7;

  assign adv           = !v7 || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // ---------------- stage 1: input decode, calendar adjust ----------------
  logic signed [14:0] year_in;
  logic [3:0]         month_in;
  logic [4:0]         day_in;
  logic [22:0]        day_number_in;

  assign year_in       = $signed(s_axis_tdata[14:0]);
  assign month_in      = s_axis_tdata[18:15];
  assign day_in        = s_axis_tdata[23:19];
  assign day_number_in = s_axis_tdata[46:24];

  logic signed [15:0] yy_next;
  logic [3:0]         mm_next;
  logic               greg_date_next;

  always_comb begin
    yy_next = 16'(year_in);
    mm_next = month_in;
    // no year zero: shift BC years up by one
    if (yy_next < 0) yy_next = yy_next + 16'sd1;
    // January and February count as months 13 and 14 of the year before
    if (month_in <= 4'd2) begin
      yy_next = yy_next - 16'sd1;
      mm_next = month_in + 4'd12;
    end
    greg_date_next = (yy_next > jdc_pkg::GREG_YEAR) ||
                     ((yy_next == jdc_pkg::GREG_YEAR) &&
                      ((mm_next > jdc_pkg::GREG_MONTH) ||
                       ((mm_next == jdc_pkg::GREG_MONTH) && (day_in >= jdc_pkg::GREG_DAY))));
  end

  jdc_pkg::op_t       s1_op;
  logic signed [15:0] s1_yy;
  logic [3:0]         s1_mm;
  logic [4:0]         s1_dd;
  logic               s1_greg_date;
  logic [22:0]        s1_z;
  logic               s1_greg_jd;
  logic [24:0]        s1_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op        <= jdc_pkg::op_t'(s_axis_tuser);
      s1_yy        <= yy_next;
      s1_mm        <= mm_next;
      s1_dd        <= day_in;
      s1_greg_date <= greg_date_next;
      s1_z         <= day_number_in;
      s1_greg_jd   <= (day_number_in >= jdc_pkg::GREG_SWITCH_JD);
      s1_w         <= 25'({day_number_in, 2'b00}) - 25'(jdc_pkg::ALPHA_OFS4);
    end
  end

  // ---------------- stage 2: year days, century and alpha products ----------------
  logic signed [25:0] yy26;
  assign yy26 = 26'(s1_yy);

  jdc_pkg::op_t       s2_op;
  logic signed [25:0] s2_t;
  logic [9:0]         s2_md;
  logic [26:0]        s2_aprod;
  logic               s2_greg_date;
  logic [22:0]        s2_z;
  logic               s2_greg_jd;
  logic [50:0]        s2_alpha_prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op         <= s1_op;
      // floor(365.25 * y) is exact as 365*y + floor(y/4) for either sign
      s2_t          <= yy26 * 26'sd365 + (yy26 >>> 2);
      s2_md         <= 10'(jdc_pkg::month_days(5'(s1_mm) + 5'd1)) + 10'(s1_dd);
      s2_aprod      <= 27'(s1_yy[13:0]) * 27'(jdc_pkg::Y100_RECIP);
      s2_greg_date  <= s1_greg_date;
      s2_z          <= s1_z;
      s2_greg_jd    <= s1_greg_jd;
      s2_alpha_prod <= 51'(s1_w) * 51'(jdc_pkg::ALPHA_RECIP);
    end
  end

  // ---------------- stage 3: day number sum; corrected day count ----------------
  logic [7:0]         cent;
  logic signed [25:0] cent26;
  logic signed [25:0] bcorr;
  logic [7:0]         alpha;
  logic [23:0]        aa;
  logic [23:0]        bb_next;

  always_comb begin
    cent   = s2_aprod[jdc_pkg::Y100_SHIFT +: 8];
    cent26 = $signed({18'd0, cent});
    bcorr  = s2_greg_date ? (26'sd2 - cent26 + (cent26 >>> 2)) : 26'sd0;
    alpha  = s2_alpha_prod[jdc_pkg::ALPHA_SHIFT +: 8];
    aa     = s2_greg_jd ? ({1'b0, s2_z} + 24'd1 + 24'(alpha) - 24'(alpha[7:2]))
                        : {1'b0, s2_z};
    bb_next = aa + jdc_pkg::B_OFFSET;
  end

  jdc_pkg::op_t s3_op;
  logic [22:0]  s3_jd;
  logic [23:0]  s3_bb;
  logic [25:0]  s3_w2;

  logic signed [25:0] jd_sum;
  assign jd_sum = s2_t + $signed({16'd0, s2_md}) + jdc_pkg::JD_DATE_OFFSET + bcorr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op <= s2_op;
      s3_jd <= jd_sum[22:0];
      s3_bb <= bb_next;
      s3_w2 <= {bb_next, 2'b00} - jdc_pkg::C_OFS4;
    end
  end

  // ---------------- stage 4: year count product ----------------
  jdc_pkg::op_t s4_op;
  logic [22:0]  s4_jd;
  logic [23:0]  s4_bb;
  logic [52:0]  s4_cprod;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_op    <= s3_op;
      s4_jd    <= s3_jd;
      s4_bb    <= s3_bb;
      s4_cprod <= 53'(s3_w2) * 53'(jdc_pkg::C_RECIP);
    end
  end

  // ---------------- stage 5: days into the year ----------------
  logic [14:0] cc;
  logic [23:0] dd24;

  assign cc   = s4_cprod[jdc_pkg::C_SHIFT +: 15];
  assign dd24 = 24'(cc) * 24'd365 + 24'(cc[14:2]);

  jdc_pkg::op_t s5_op;
  logic [22:0]  s5_jd;
  logic [14:0]  s5_c;
  logic [9:0]   s5_x;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_op <= s4_op;
      s5_jd <= s4_jd;
      s5_c  <= cc;
      s5_x  <= 10'(s4_bb - dd24);
    end
  end

  // ---------------- stage 6: month count product ----------------
  jdc_pkg::op_t s6_op;
  logic [22:0]  s6_jd;
  logic [14:0]  s6_c;
  logic [9:0]   s6_x;
  logic [35:0]  s6_eprod;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_op    <= s5_op;
      s6_jd    <= s5_jd;
      s6_c     <= s5_c;
      s6_x     <= s5_x;
      s6_eprod <= 36'(s5_x) * 36'(jdc_pkg::E_RECIP);
    end
  end

  // ---------------- stage 7: date fields, output register ----------------
  logic [3:0]         ee;
  logic [3:0]         month_res;
  logic [4:0]         day_res;
  logic signed [15:0] year_res;

  always_comb begin
    ee        = s6_eprod[jdc_pkg::E_SHIFT +: 4];
    month_res = (ee < 4'd14) ? (ee - 4'd1) : (ee - 4'd13);
    day_res   = 5'(s6_x - 10'(jdc_pkg::month_days(5'(ee))));
    year_res  = $signed({1'b0, s6_c}) -
                ((month_res > 4'd2) ? jdc_pkg::YEAR_BASE_LATE : jdc_pkg::YEAR_BASE_EARLY);
    // back to historical numbering, no year zero
    if (year_res <= 0) year_res = year_res - 16'sd1;
  end

  jdc_pkg::op_t s7_op;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_op <= s6_op;
      if (s6_op == jdc_pkg::OP_DATE_TO_JD) begin
        m_axis_tdata <= {25'd0, s6_jd};
      end else begin
        m_axis_tdata <= {1'b0, day_res, month_res, year_res[14:0], 23'd0};
      end
    end
  end

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && s7_op == jdc_pkg::OP_JD_TO_DATE) |->
      (m_axis_tdata[41:38] >= 4'd1 && m_axis_tdata[41:38] <= 4'd12))
    else $error("month from day number out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && s7_op == jdc_pkg::OP_JD_TO_DATE) |->
      (m_axis_tdata[46:42] >= 5'd1 && m_axis_tdata[46:42] <= 5'd31))
    else $error("day from day number out of range");

  a_fwd_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && s7_op == jdc_pkg::OP_DATE_TO_JD) |-> (m_axis_tdata[47:23] == 25'd0))
    else $error("date fields set on a day number result");

endmodule

`default_nettype wire

>>> tb/tb_julian_day_converter.sv
// Self-checking testbench for julian_day_converter: directed table, then random requests.
module tb_julian_day_converter;

  localparam int RANDOM_REQUESTS = 625;
  localparam int HOLD_AFTER      = 300;   // accepted requests before the long output stall
  localparam int HOLD_CYCLES     = 120;
  localparam int DRAIN_CYCLES    = 20;

  // Meeus constants, fractions scaled by 100 or 10000
  localparam longint GREG_FIRST_DATE = 15821015;
  localparam longint GREG_FIRST_JDN  = 2299161;
  localparam longint DATE_OFFSET     = 1720995;
  localparam longint ALPHA_BASE      = 186721625;
  localparam longint CENTURY_X100    = 3652425;
  localparam longint YEAR_X100       = 36525;
  localparam longint BC_CORR_X100    = 75;
  localparam longint MONTH_X10000    = 306001;
  localparam longint EPOCH_SHIFT     = 1524;
  localparam longint C_BASE_X100     = 12210;
  localparam longint YEAR_BASE_LATE  = 4716;
  localparam longint YEAR_BASE_EARLY = 4715;
  localparam int     JDN_LAST        = 5373484;

  typedef struct packed {
    logic [jdc_pkg::JD_W-1:0]          jdn;
    logic signed [jdc_pkg::YEAR_W-1:0] year;
    logic [jdc_pkg::MONTH_W-1:0]       month;
    logic [jdc_pkg::DAY_W-1:0]         day;
  } conv_result_t;

  typedef struct {
    jdc_pkg::op_t op;
    int           year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic [22:0]  jdn;
    bit           known;
    conv_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  conv_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int date_reqs = 0;
  int jdn_reqs = 0;
  int burst_left = 0;
  conv_result_t got, want;

  julian_day_converter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("timeout at %0t, %0d results still outstanding", $time, pending_results.size());
    $display("tb_julian_day_converter: errors");
    $finish;
  end

  function automatic conv_result_t predict_conversion(jdc_pkg::op_t op, logic [47:0] req);
    conv_result_t r;
    longint y, m, d, z, corr, a, b, alpha, c, dd, e, mo;
    r = '0;
    if (op == jdc_pkg::OP_DATE_TO_JD) begin
      y = $signed(req[14:0]);
      m = req[18:15];
      d = req[23:19];
      if (y < 0) y++;                  // no year zero
      corr = (y > 0) ? 0 : BC_CORR_X100;
      if (m <= 2) begin
        y--;
        m += 12;
      end
      b = 0;
      if (y * 10000 + m * 100 + d >= GREG_FIRST_DATE) begin
        a = y / 100;
        b = 2 - a + a / 4;
      end
      r.jdn = 23'((YEAR_X100 * y - corr) / 100 + (MONTH_X10000 * (m + 1)) / 10000
                  + d + DATE_OFFSET + b);
    end else begin
      z = req[46:24];
      if (z < GREG_FIRST_JDN) begin
        a = z;
      end else begin
        alpha = (100 * z - ALPHA_BASE) / CENTURY_X100;
        a = z + 1 + alpha - alpha / 4;
      end
      b = a + EPOCH_SHIFT;
      c = (100 * b - C_BASE_X100) / YEAR_X100;
      dd = (YEAR_X100 * c) / 100;
      e = (10000 * (b - dd)) / MONTH_X10000;
      r.day = 5'(b - dd - (MONTH_X10000 * e) / 10000);
      mo = (e < 14) ? e - 1 : e - 13;
      y = (mo > 2) ? c - YEAR_BASE_LATE : c - YEAR_BASE_EARLY;
      if (y <= 0) y--;
      r.month = 4'(mo);
      r.year = 15'(y);
    end
    return r;
  endfunction

  function automatic logic [47:0] pack_request(int year, logic [3:0] month, logic [4:0] day,
                                               logic [22:0] jdn);
    logic [14:0] y;
    y = year[14:0];
    return {1'b0, jdn, day, month, y};
  endfunction

  task automatic add_row(jdc_pkg::op_t op, int year, logic [3:0] month, logic [4:0] day,
                         logic [22:0] jdn, bit known, logic [22:0] w_jdn, int w_year,
                         logic [3:0] w_month, logic [4:0] w_day);
    stim_row_t row;
    row.op = op;
    row.year = year;
    row.month = month;
    row.day = day;
    row.jdn = jdn;
    row.known = known;
    row.want.jdn = w_jdn;
    row.want.year = w_year[14:0];
    row.want.month = w_month;
    row.want.day = w_day;
    directed_rows.push_back(row);
  endtask

  // Offers one request, bursting with random gaps, and books its result once accepted.
  task automatic send_request(jdc_pkg::op_t op, logic [47:0] data, conv_result_t expected);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(expected);
    accepted++;
    if (op == jdc_pkg::OP_DATE_TO_JD) date_reqs++;
    else jdn_reqs++;
  endtask

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // output side: random stall phases plus one long hold-off
  initial begin : receiver
    int phase_left;
    int stall_pct;
    bit held;
    phase_left = 0;
    stall_pct = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && accepted >= HOLD_AFTER) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.jdn = m_axis_tdata[22:0];
      got.year = m_axis_tdata[37:23];
      got.month = m_axis_tdata[41:38];
      got.day = m_axis_tdata[46:42];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("day_number_out", want.jdn, got.jdn);
        check_field("year_out", want.year, got.year);
        check_field("month_out", want.month, got.month);
        check_field("day_out", want.day, got.day);
        checked++;
      end
    end
  end

  initial begin : stimulus
    stim_row_t    row;
    logic [47:0]  data;
    jdc_pkg::op_t op;
    int           yr;
    int           pick;
    logic [3:0]   mo;
    logic [4:0]   dy;
    logic [22:0]  jdn;

    // date to day number: switch-over days, epoch and 2000-01-01 typed in, odd dates predicted
    add_row(jdc_pkg::OP_DATE_TO_JD, -4713, 1, 1, 23'h7FFFFF, 1, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 1582, 10, 4, 0, 1, 2299160, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 1582, 10, 15, 0, 1, 2299161, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 2000, 1, 1, 0, 1, 2451545, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 9999, 12, 31, 0, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 0, 6, 15, 0, 0, 0, 0, 0, 0);     // year zero acts as 1 BC
    add_row(jdc_pkg::OP_DATE_TO_JD, -1, 12, 31, 0, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 1, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 2023, 2, 30, 0, 0, 0, 0, 0, 0);  // past the end of February
    add_row(jdc_pkg::OP_DATE_TO_JD, 1900, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 1700, 15, 31, 0, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, -16384, 1, 1, 0, 0, 0, 0, 0, 0); // wraps below zero
    add_row(jdc_pkg::OP_DATE_TO_JD, 16383, 12, 31, 0, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_DATE_TO_JD, 1582, 10, 10, 0, 0, 0, 0, 0, 0); // inside the dropped days
    // day number to date
    add_row(jdc_pkg::OP_JD_TO_DATE, -1, 15, 31, 0, 1, 0, -4713, 1, 1);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 2299160, 1, 0, 1582, 10, 4);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 2299161, 1, 0, 1582, 10, 15);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 2451545, 1, 0, 2000, 1, 1);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 23'(JDN_LAST), 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 23'h7FFFFF, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 1721423, 0, 0, 0, 0, 0);
    add_row(jdc_pkg::OP_JD_TO_DATE, 0, 0, 0, 1721424, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      data = pack_request(row.year, row.month, row.day, row.jdn);
      send_request(row.op, data, row.known ? row.want : predict_conversion(row.op, data));
    end

    // random requests: mostly in-range, some near the calendar switch, some full-width
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      op = jdc_pkg::op_t'($urandom_range(0, 1));
      yr = $urandom_range(0, 32767);
      mo = 4'($urandom_range(0, 15));
      dy = 5'($urandom_range(0, 31));
      jdn = 23'($urandom_range(0, 23'h7FFFFF));
      pick = $urandom_range(0, 9);
      if (op == jdc_pkg::OP_DATE_TO_JD) begin
        if (pick < 6) begin
          yr = int'($urandom_range(0, 14712)) - 4713;
          mo = 4'($urandom_range(1, 12));
          dy = 5'($urandom_range(1, 31));
        end else if (pick < 8) begin
          yr = 1581 + int'($urandom_range(0, 2));
          mo = 4'($urandom_range(9, 11));
          dy = 5'($urandom_range(1, 31));
        end
      end else begin
        if (pick < 6) jdn = 23'($urandom_range(0, JDN_LAST));
        else if (pick < 8) jdn = 23'(GREG_FIRST_JDN - 100 + $urandom_range(0, 200));
      end
      data = pack_request(yr, mo, dy, jdn);
      send_request(op, data, predict_conversion(op, data));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d dates to day numbers, %0d day numbers to dates",
             accepted, date_reqs, jdn_reqs);
    $display("%0d results compared under random stalls and one long output hold-off",
             checked);
    if (errors == 0) begin
      $display("tb_julian_day_converter: clean");
    end else begin
      $display("tb_julian_day_converter: errors");
    end
    $finish;
  end

endmodule
